// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Property templates for the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gdd_pkg
// Types, constants, microcode word and calendar tables of the date difference.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int YEAR_MAX_DEF = 9999;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 22;
  localparam int SERIAL_W = 23;
  localparam int PROD_W  = 27;
  localparam int STEP_W  = 4;

  // floor(x / 100) == (x * 5243) >> 19 for every 14-bit x
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SHIFT = 19;
  localparam logic [8:0]  DAYS_YEAR = 9'd365;

  typedef struct packed {
    logic [YEAR_W-1:0]  year_a;
    logic [MONTH_W-1:0] month_a;
    logic [DAY_W-1:0]   day_a;
    logic [YEAR_W-1:0]  year_b;
    logic [MONTH_W-1:0] month_b;
    logic [DAY_W-1:0]   day_b;
  } in_t;

  typedef struct packed {
    logic               dates_valid;
    logic [COUNT_W-1:0] day_count;
  } out_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MULY,   // product = year * 1/100 reciprocal
    OP_LEAP,   // leap flag from year / 100
    OP_CHK,    // check date, load day-of-year
    OP_MULP,   // product = (year - 1) * 1/100 reciprocal
    OP_LEAPS,  // add leap days of earlier years
    OP_M365,   // add 365 * year
    OP_SAVE,   // park first serial number
    OP_FIN     // form the result
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              sel_b;
    logic              jmp_bad;
    logic              last;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic ok;
  } stat_t;

  // Month length, February as a common year; zero for codes that are no month
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before month m, common year
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/gdd_seq.sv =====
// ----------------------------------------------------------------------------
// gdd_seq
// Step counter and microcode table; issues one control word per step.
// ----------------------------------------------------------------------------
module gdd_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               adv,
  input  gdd_pkg::stat_t     stat,
  output gdd_pkg::ctrl_t     ctrl
);

  localparam logic [gdd_pkg::STEP_W-1:0] STEP_FIN = 4'd13;

  logic [gdd_pkg::STEP_W-1:0] step_r, step_nxt;

  // Program: date A, park its serial, date B, then finish.
  // A bad date skips straight to the finish step.
  function automatic gdd_pkg::ctrl_t rom(input logic [gdd_pkg::STEP_W-1:0] s);
    gdd_pkg::ctrl_t w;
    w = '{op: gdd_pkg::OP_NOP, sel_b: 1'b0, jmp_bad: 1'b0, last: 1'b0, target: STEP_FIN};
    unique case (s)
      4'd0:  w.op = gdd_pkg::OP_MULY;
      4'd1:  w.op = gdd_pkg::OP_LEAP;
      4'd2:  w.op = gdd_pkg::OP_CHK;
      4'd3:  begin
        w.op = gdd_pkg::OP_MULP;
        w.jmp_bad = 1'b1;
      end
      4'd4:  w.op = gdd_pkg::OP_LEAPS;
      4'd5:  w.op = gdd_pkg::OP_M365;
      4'd6:  w.op = gdd_pkg::OP_SAVE;
      4'd7:  begin
        w.op = gdd_pkg::OP_MULY;
        w.sel_b = 1'b1;
      end
      4'd8:  begin
        w.op = gdd_pkg::OP_LEAP;
        w.sel_b = 1'b1;
      end
      4'd9:  begin
        w.op = gdd_pkg::OP_CHK;
        w.sel_b = 1'b1;
      end
      4'd10: begin
        w.op = gdd_pkg::OP_MULP;
        w.sel_b = 1'b1;
        w.jmp_bad = 1'b1;
      end
      4'd11: begin
        w.op = gdd_pkg::OP_LEAPS;
        w.sel_b = 1'b1;
      end
      4'd12: begin
        w.op = gdd_pkg::OP_M365;
        w.sel_b = 1'b1;
      end
      default: begin
        w.op = gdd_pkg::OP_FIN;
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(step_r);

  // Restart on a new item, jump on a bad date, else step forward
  always_comb begin
    step_nxt = step_r;
    priority if (start) begin
      step_nxt = '0;
    end else if (adv && ctrl.jmp_bad && !stat.ok) begin
      step_nxt = ctrl.target;
    end else if (adv && !ctrl.last) begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/gdd_dp.sv =====
// ----------------------------------------------------------------------------
// gdd_dp
// Date datapath: reciprocal multiply, leap test, checks and serial day sum.
// ----------------------------------------------------------------------------
module gdd_dp #(
  parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
  input  logic            clk,
  input  logic            start,
  input  gdd_pkg::in_t    in_data,
  input  logic            exec,
  input  gdd_pkg::ctrl_t  ctrl,
  output gdd_pkg::stat_t  stat,
  output gdd_pkg::out_t   res
);

  localparam logic [16:0] YMAX = 17'(YEAR_MAX);

  gdd_pkg::in_t                   item_r;
  logic                           ok_r;
  logic                           leap_r;
  logic [gdd_pkg::PROD_W-1:0]     prod_r;
  logic [gdd_pkg::SERIAL_W-1:0]   acc_r;
  logic [gdd_pkg::SERIAL_W-1:0]   sa_r;

  logic [gdd_pkg::YEAR_W-1:0]     y;
  logic [gdd_pkg::YEAR_W-1:0]     p;
  logic [gdd_pkg::MONTH_W-1:0]    m;
  logic [gdd_pkg::DAY_W-1:0]      d;
  logic [7:0]                     q100;
  logic [14:0]                    q_x100;
  logic                           div100;
  logic [gdd_pkg::DAY_W-1:0]      len;
  logic                           date_good;
  logic [11:0]                    leaps;
  logic [gdd_pkg::SERIAL_W-1:0]   diff;

  // Pick the date that this step works on
  always_comb begin
    if (ctrl.sel_b) begin
      y = item_r.year_b;
      m = item_r.month_b;
      d = item_r.day_b;
    end else begin
      y = item_r.year_a;
      m = item_r.month_a;
      d = item_r.day_a;
    end
  end

  assign p      = y - 14'd1;
  assign q100   = prod_r[gdd_pkg::RECIP_SHIFT +: 8];
  assign q_x100 = 15'(q100) * 15'd100;
  assign div100 = (15'(y) == q_x100);

  // Month length with the leap day, then the validity test
  always_comb begin
    len = gdd_pkg::month_len(m);
    if (m == 4'd2 && leap_r) begin
      len = 5'd29;
    end
    date_good = (17'(y) <= YMAX) && (m >= 4'd1) && (m <= 4'd12) &&
                (d >= 5'd1) && (d <= len);
  end

  // Leap years in 0 .. y-1
  assign leaps = (y == '0) ? 12'd0 :
                 (p[13:2] - 12'(q100) + 12'(q100[7:2]) + 12'd1);

  // Absolute difference, saturated to the count width
  always_comb begin
    diff = (sa_r > acc_r) ? (sa_r - acc_r) : (acc_r - sa_r);
    res.dates_valid = ok_r;
    if (!ok_r) begin
      res.day_count = '0;
    end else if (diff[gdd_pkg::SERIAL_W-1]) begin
      res.day_count = '1;
    end else begin
      res.day_count = diff[gdd_pkg::COUNT_W-1:0];
    end
  end

  assign stat.ok = ok_r;

  // Load a new item or run the current micro-op
  always_ff @(posedge clk) begin
    if (start) begin
      item_r <= in_data;
      ok_r   <= 1'b1;
    end else if (exec) begin
      unique case (ctrl.op)
        gdd_pkg::OP_MULY:
          prod_r <= 27'(y) * 27'(gdd_pkg::RECIP_100);
        gdd_pkg::OP_LEAP:
          leap_r <= (y[1:0] == 2'd0 && !div100) || (div100 && q100[1:0] == 2'd0);
        gdd_pkg::OP_CHK: begin
          ok_r  <= ok_r && date_good;
          acc_r <= 23'(gdd_pkg::days_before(m)) + 23'(d) +
                   23'((m > 4'd2) && leap_r);
        end
        gdd_pkg::OP_MULP:
          prod_r <= 27'(p) * 27'(gdd_pkg::RECIP_100);
        gdd_pkg::OP_LEAPS:
          acc_r <= acc_r + 23'(leaps);
        gdd_pkg::OP_M365:
          acc_r <= acc_r + 23'(y) * 23'(gdd_pkg::DAYS_YEAR);
        gdd_pkg::OP_SAVE:
          sa_r <= acc_r;
        gdd_pkg::OP_NOP, gdd_pkg::OP_FIN: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/gregorian_date_difference_top.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_difference_top
// Days between two Gregorian dates, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries two dates. A transfer
//   happens when in_valid is high and in_stall is low. in_stall stays high
//   while the sequencer works on an item, so one item is in flight at a time.
//   Output channel out_valid / out_stall / out_data gives one result per item:
//   dates_valid and day_count (zero when either date is invalid).
//   For valid dates an item runs through every step of the microcode program
//   of 14 steps, one datapath operation per step; when date A or date B is
//   invalid, the program skips ahead to the finish step. A new item is taken
//   only once the sequencer has finished the current one.
//   The output register holds the result while out_stall is high, and a new
//   item is taken meanwhile; it finishes its steps and waits at the last
//   step until the register frees up.
//   Reset (rst_n low, synchronous) clears the sequencer, the busy flag and out_valid.
// ----------------------------------------------------------------------------
module gregorian_date_difference_top #(
  parameter int YEAR_MAX = gdd_pkg::YEAR_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  gdd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output gdd_pkg::out_t  out_data
);

  logic           busy_r, busy_nxt;
  logic           out_valid_r, out_valid_nxt;
  gdd_pkg::out_t  out_r;

  gdd_pkg::ctrl_t ctrl;
  gdd_pkg::stat_t stat;
  gdd_pkg::out_t  res;

  logic start;
  logic out_free;
  logic fin;
  logic adv;

  assign start    = in_valid && !busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign fin      = busy_r && ctrl.last && out_free;
  // Hold at the last step while the output register holds a stalled result
  assign adv      = busy_r && (!ctrl.last || out_free);

  gdd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .adv   (adv),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  gdd_dp #(
    .YEAR_MAX (YEAR_MAX)
  ) u_dp (
    .clk     (clk),
    .start   (start),
    .in_data (in_data),
    .exec    (adv),
    .ctrl    (ctrl),
    .stat    (stat),
    .res     (res)
  );

  // Track the busy flag and the output register
  always_comb begin
    busy_nxt = busy_r;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (fin) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the result on the finishing step
  always_ff @(posedge clk) begin
    if (fin) begin
      out_r <= res;
    end
  end

  assign in_stall  = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/gdd_check.sv =====
// ----------------------------------------------------------------------------
// gdd_check
// Port-level checks of the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdd_check (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input gdd_pkg::in_t   in_data,
  input logic           out_valid,
  input logic           out_stall,
  input gdd_pkg::out_t  out_data
);

  // An invalid pair reports a zero count
  `ASSERT_IMPL(a_bad_zero, out_valid && !out_data.dates_valid, out_data.day_count == 22'd0)

  // A transfer in makes the block busy for the next cycle
  `ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)

  // A stalled result stays and holds its value
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // No result appears in the cycle right after an input transfer
  `ASSERT_NEXT(a_no_early_out, in_valid && !in_stall && !(out_valid && out_stall), !out_valid)

endmodule

bind gregorian_date_difference_top gdd_check u_check (.*);
